>>> design/rotating_server_assigner_defines.svh
// Assertion macros used by the rotating server assigner top level.
`ifndef ROTATING_SERVER_ASSIGNER_DEFINES_SVH
`define ROTATING_SERVER_ASSIGNER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RSA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rotating_server_assigner: assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rotating_server_assigner: assertion failed");
`else
`define RSA_ASSERT_IMPL(label, ante, cons)
`define RSA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/rsa_pkg.sv
// Shared constants, types and helper functions of the rotating server assigner.
package rsa_pkg;

  localparam int SERVERS_DEF = 16;
  localparam int MAX_INDEXED = 16;

  localparam int ACTIVE_W = 5;
  localparam int TIME_W   = 32;
  localparam int DUR_W    = 16;
  localparam int CNT_W    = 32;
  localparam int OUT_IDX_W = 4;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);

  localparam logic OPC_ASSIGN = 1'b0;
  localparam logic OPC_REPORT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ASSIGN,
    S_MAX,
    S_EMIT
  } state_t;

  // Control handed from the sequencer to one cell.
  typedef struct packed {
    logic              shift;
    logic              wr;
    logic [TIME_W-1:0] fin;
  } cell_ctl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    return r;
  endfunction

endpackage

>>> design/rsa_cell.sv
// One server cell: finish time, handled count and the count ring link.
module rsa_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rsa_pkg::cell_ctl_t         ctl,
  input  logic [rsa_pkg::TIME_W-1:0] arrival,
  input  logic [rsa_pkg::CNT_W-1:0]  count_in,
  output logic [rsa_pkg::CNT_W-1:0]  count_out,
  output logic                       free
);

  logic [rsa_pkg::TIME_W-1:0] finish_r, finish_nxt;
  logic [rsa_pkg::CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    finish_nxt = finish_r;
    count_nxt  = count_r;
    if (ctl.wr) begin
      finish_nxt = ctl.fin;
      count_nxt  = rsa_pkg::sat_inc(count_r);
    end else if (ctl.shift) begin
      count_nxt = count_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finish_r <= '0;
      count_r  <= '0;
    end else begin
      finish_r <= finish_nxt;
      count_r  <= count_nxt;
    end
  end

  assign free      = (finish_r <= arrival);
  assign count_out = count_r;

endmodule

>>> design/rsa_pick.sv
// Rotating priority pick of the first free active server from a start index.
module rsa_pick #(
  parameter int N  = 16,
  parameter int IW = 4
) (
  input  logic [N-1:0]                  free,
  input  logic [rsa_pkg::ACTIVE_W-1:0]  active,
  input  logic [IW-1:0]                 start,
  output logic                          found,
  output logic [IW-1:0]                 sel
);

  logic          found_hi;
  logic          found_any;
  logic [IW-1:0] sel_hi;
  logic [IW-1:0] sel_any;

  // Scan downwards so that the lowest qualifying index wins.
  always_comb begin
    found_hi  = 1'b0;
    found_any = 1'b0;
    sel_hi    = '0;
    sel_any   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (free[i] && (rsa_pkg::ACTIVE_W'(i) < active)) begin
        found_any = 1'b1;
        sel_any   = IW'(i);
        if (IW'(i) >= start) begin
          found_hi = 1'b1;
          sel_hi   = IW'(i);
        end
      end
    end
  end

  assign found = found_any;
  assign sel   = found_hi ? sel_hi : sel_any;

endmodule

>>> design/rotating_server_assigner.sv
// Top level of the rotating server assigner: sequencer, cell ring and output register.

// Each server is a cell holding its finish time and handled count. For an
// assign beat (in_tuser low) the accepting cycle registers every cell's free
// flag against the arrival time and the saturated finish time, and the next
// cycle picks the first free active server from the rotation position
// onwards, writes that cell and loads the single result beat; it waits there
// only while the output register is still full. For a report beat (in_tuser
// high) the counts circulate once round the cell ring to find the highest
// count and the last server holding it, then circulate once more while each
// matching active server is emitted in ascending order, the final one with
// out_tlast. The ring length sets the report time, together with any output
// stall. One output register sits between the engine and the result channel,
// so a new beat is accepted while a result is still waiting. Servers beyond
// sixteen are never used, and active_servers is clamped to between one and
// the number of cells.
`include "rotating_server_assigner_defines.svh"

module rotating_server_assigner #(
  parameter int SERVERS = rsa_pkg::SERVERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: arrival_time [31:0], duration [47:32]
  input  logic [47:0]                    in_tdata,
  // in_tuser: opcode
  input  logic                           in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: server_index [3:0], handled_count [35:4], zero [39:36]
  output logic [39:0]                    out_tdata,
  // out_tuser: accepted
  output logic                           out_tuser,
  output logic                           out_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [rsa_pkg::ACTIVE_W-1:0]   cfg_wdata
);

  localparam int NCELLS = (SERVERS < rsa_pkg::MAX_INDEXED) ? SERVERS : rsa_pkg::MAX_INDEXED;
  localparam int IW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam logic [IW-1:0] LAST_CELL = IW'(NCELLS - 1);
  localparam int AW = rsa_pkg::ACTIVE_W;
  localparam int TW = rsa_pkg::TIME_W;
  localparam int CW = rsa_pkg::CNT_W;

  // Configuration and clamped active count.
  logic [AW-1:0] active_r;
  logic [AW-1:0] active_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= rsa_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  always_comb begin
    active_k = active_r;
    if (active_r == '0) begin
      active_k = AW'(1);
    end else if (active_r > AW'(NCELLS)) begin
      active_k = AW'(NCELLS);
    end
  end

  // Input side.
  logic          in_acc;
  logic [TW-1:0] arrival;
  logic [TW:0]   fin_sum;
  logic [TW-1:0] fin_sat;

  assign in_acc  = in_tvalid && in_tready;
  assign arrival = in_tdata[TW-1:0];
  assign fin_sum = {1'b0, arrival} + (TW + 1)'(in_tdata[47:TW]);
  assign fin_sat = fin_sum[TW] ? {TW{1'b1}} : fin_sum[TW-1:0];

  // Cell ring.
  rsa_pkg::cell_ctl_t ctl    [NCELLS];
  logic [CW-1:0]      cnt    [NCELLS];
  logic [NCELLS-1:0]  free_now;

  logic                shift_en;
  logic                wr_en;
  logic [IW-1:0]       pick_sel;
  logic                pick_found;
  logic [TW-1:0]       fin_r;

  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    localparam int NEXT = (g + 1) % NCELLS;

    assign ctl[g].shift = shift_en;
    assign ctl[g].wr    = wr_en && (pick_sel == IW'(g));
    assign ctl[g].fin   = fin_r;

    rsa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[g]),
      .arrival   (arrival),
      .count_in  (cnt[NEXT]),
      .count_out (cnt[g]),
      .free      (free_now[g])
    );
  end

  // Sequencer registers.
  rsa_pkg::state_t   state_r, state_nxt;
  logic [NCELLS-1:0] free_r;
  logic [IW-1:0]     rot_r, rot_nxt;
  logic [IW-1:0]     scan_r, scan_nxt;
  logic [CW-1:0]     best_r, best_nxt;
  logic [IW-1:0]     lastidx_r, lastidx_nxt;

  logic [IW-1:0] start;
  logic [AW:0]   start_inc;
  logic          scan_act;
  logic          scan_match;
  logic          can_load;
  logic          emit_adv;
  logic          out_ld;

  assign start     = (AW'(rot_r) < active_k) ? rot_r : '0;
  assign start_inc = (AW + 1)'(start) + (AW + 1)'(1);
  assign rot_nxt   = (start_inc >= (AW + 1)'(active_k)) ? '0 : IW'(start_inc);

  assign scan_act   = AW'(scan_r) < active_k;
  assign scan_match = cnt[0] == best_r;
  assign can_load   = !out_tvalid || out_tready;
  assign emit_adv   = !(scan_act && scan_match) || can_load;
  assign scan_nxt   = (scan_r == LAST_CELL) ? '0 : scan_r + IW'(1);

  rsa_pick #(
    .N  (NCELLS),
    .IW (IW)
  ) u_pick (
    .free   (free_r),
    .active (active_k),
    .start  (start),
    .found  (pick_found),
    .sel    (pick_sel)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsa_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == rsa_pkg::OPC_REPORT) ? rsa_pkg::S_MAX : rsa_pkg::S_ASSIGN;
        end
      end
      rsa_pkg::S_ASSIGN: begin
        if (can_load) begin
          state_nxt = rsa_pkg::S_IDLE;
        end
      end
      rsa_pkg::S_MAX: begin
        if (scan_r == LAST_CELL) begin
          state_nxt = rsa_pkg::S_EMIT;
        end
      end
      rsa_pkg::S_EMIT: begin
        if (emit_adv && (scan_r == LAST_CELL)) begin
          state_nxt = rsa_pkg::S_IDLE;
        end
      end
      default: state_nxt = rsa_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    shift_en  = 1'b0;
    wr_en     = 1'b0;
    out_ld    = 1'b0;
    unique case (state_r)
      rsa_pkg::S_IDLE: begin
        in_tready = 1'b1;
      end
      rsa_pkg::S_ASSIGN: begin
        out_ld = can_load;
        wr_en  = can_load && pick_found;
      end
      rsa_pkg::S_MAX: begin
        shift_en = 1'b1;
      end
      rsa_pkg::S_EMIT: begin
        shift_en = emit_adv;
        out_ld   = scan_act && scan_match && can_load;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Running maximum and the last index holding it.
  always_comb begin
    best_nxt    = best_r;
    lastidx_nxt = lastidx_r;
    if (in_acc) begin
      best_nxt    = '0;
      lastidx_nxt = '0;
    end else if ((state_r == rsa_pkg::S_MAX) && scan_act) begin
      if (cnt[0] > best_r) begin
        best_nxt = cnt[0];
      end
      if (cnt[0] >= best_r) begin
        lastidx_nxt = scan_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsa_pkg::S_IDLE;
      rot_r   <= '0;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == rsa_pkg::S_ASSIGN) && can_load) begin
        rot_r <= rot_nxt;
      end
      if (in_acc) begin
        scan_r <= '0;
      end else if (shift_en) begin
        scan_r <= scan_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_r    <= best_nxt;
    lastidx_r <= lastidx_nxt;
    if (in_acc) begin
      free_r <= free_now;
      fin_r  <= fin_sat;
    end
  end

  // Output register.
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_acc_r, out_acc_nxt;
  logic [rsa_pkg::OUT_IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [CW-1:0]                   out_cnt_r, out_cnt_nxt;
  logic                            out_last_r, out_last_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_acc_nxt   = out_acc_r;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    if (out_ld) begin
      out_valid_nxt = 1'b1;
      if (state_r == rsa_pkg::S_EMIT) begin
        out_acc_nxt  = 1'b1;
        out_idx_nxt  = rsa_pkg::OUT_IDX_W'(scan_r);
        out_cnt_nxt  = best_r;
        out_last_nxt = scan_r == lastidx_r;
      end else begin
        // A dropped request reports index and count as zero.
        out_acc_nxt  = pick_found;
        out_idx_nxt  = pick_found ? rsa_pkg::OUT_IDX_W'(pick_sel) : '0;
        out_cnt_nxt  = pick_found ? rsa_pkg::sat_inc(cnt[pick_sel]) : '0;
        out_last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_acc_r  <= out_acc_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_acc_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_cnt_r, out_idx_r};

  // The engine takes no beat while a request or report is in progress.
  `RSA_ASSERT_IMPL(a_busy_no_accept, state_r != rsa_pkg::S_IDLE, !in_tready)
  // A dropped request carries a zero index and count.
  `RSA_ASSERT_IMPL(a_drop_zero, out_tvalid && !out_tuser, out_tdata == 40'd0)
  // A report ends only after the ring has come fully round.
  `RSA_ASSERT_IMPL(a_ring_restored,
    (state_r == rsa_pkg::S_EMIT) && (state_nxt == rsa_pkg::S_IDLE), scan_r == LAST_CELL)
  // An assign commit always loads the output register.
  `RSA_ASSERT_NEXT(a_assign_loads,
    (state_r == rsa_pkg::S_ASSIGN) && can_load, out_tvalid && out_tlast)

endmodule
